FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/dcc_pkg.sv
// Types, codes and helpers shared by the DMA channel controller.
package dcc_pkg;

  localparam int CHANNELS_DEF = 4;
  // Channels reachable through the 2-bit channel field.
  localparam int MAX_CH       = 4;
  // Register file address: {channel, reg_select}.
  localparam int RF_AW        = 4;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  localparam logic [1:0] SEL_SRC  = 2'd0;
  localparam logic [1:0] SEL_DST  = 2'd1;
  localparam logic [1:0] SEL_CNT  = 2'd2;
  localparam logic [1:0] SEL_CTRL = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_XFER = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_INC   = 2'd1;
  localparam logic [1:0] MODE_DEC   = 2'd2;
  localparam logic [1:0] MODE_BAD   = 2'd3;

  localparam logic [15:0] PAT_MASK = 16'h0ff0;
  localparam logic [15:0] PAT_WANT = 16'h0c10;
  localparam logic [15:0] CTRL_DONE = 16'h0002;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  channel;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [1:0]  xfer_channel;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        word_size;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic             we;
    logic [RF_AW-1:0] waddr;
    logic [31:0]      wdata;
    logic [RF_AW-1:0] raddr;
  } rf_cmd_t;

  typedef struct packed {
    logic [31:0]       rdata;
    logic [MAX_CH-1:0] elig;
  } rf_stat_t;

  // Address step for one unit under the given mode.
  function automatic logic [31:0] mode_step(input logic [1:0] mode, input logic word);
    logic [31:0] size;
    logic [31:0] step;
    size = word ? 32'd2 : 32'd1;
    case (mode)
      MODE_INC: step = size;
      MODE_DEC: step = 32'd0 - size;
      default:  step = 32'd0;
    endcase
    return step;
  endfunction

endpackage

FILE: design/dcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/dcc_regfile.sv
// Channel register file: RAM with per-entry valid bits and enable/done mirrors.
module dcc_regfile
  import dcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  rf_cmd_t  cmd,
  output rf_stat_t stat
);

  localparam int NCH   = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int DEPTH = NCH * 4;
  localparam int AW    = $clog2(DEPTH);

  logic [DEPTH-1:0] valid_r;
  logic             rd_valid_r;
  logic [NCH-1:0]   en_r;
  logic [NCH-1:0]   done_r;
  logic [31:0]      ram_q;

  dcc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr[AW-1:0]),
    .wdata (cmd.wdata),
    .raddr (cmd.raddr[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      en_r       <= '0;
      done_r     <= '0;
    end else begin
      rd_valid_r <= valid_r[cmd.raddr[AW-1:0]];
      if (cmd.we) begin
        valid_r[cmd.waddr[AW-1:0]] <= 1'b1;
      end
      // Mirror enable and done so the tick can pick a channel without a read.
      for (int i = 0; i < NCH; i++) begin
        if (cmd.we && cmd.waddr[1:0] == SEL_CTRL && cmd.waddr[3:2] == 2'(i)) begin
          en_r[i]   <= cmd.wdata[0];
          done_r[i] <= cmd.wdata[1];
        end
      end
    end
  end

  always_comb begin
    stat.rdata = rd_valid_r ? ram_q : 32'd0;
    stat.elig  = '0;
    for (int i = 0; i < NCH; i++) begin
      stat.elig[i] = en_r[i] & ~done_r[i];
    end
  end

endmodule

FILE: design/dcc_engine.sv
// Request sequencer: bus accesses, channel pick, transfer stepping and results.
module dcc_engine
  import dcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  input  logic     master_en,
  output rf_cmd_t  cmd,
  input  rf_stat_t stat,
  output logic     out_valid,
  output out_res_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CTRL,
    ST_SRC,
    ST_DST,
    ST_CNT,
    ST_XFER
  } state_t;

  state_t      state_r, state_nxt;
  in_req_t     req_r, req_nxt;
  logic [1:0]  pick_r, pick_nxt;
  logic [15:0] ctrl_r, ctrl_nxt;
  logic        run_r, run_nxt;
  logic [1:0]  active_r, active_nxt;
  logic [31:0] cur_src_r, cur_src_nxt;
  logic [31:0] cur_dst_r, cur_dst_nxt;
  logic [15:0] cur_rem_r, cur_rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_r, out_nxt;

  logic        accept;
  logic        ch_ok;
  logic        found;
  logic [1:0]  pick_sel;
  logic [15:0] rd_ctrl;
  logic        ctrl_ok;
  logic        last;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign ch_ok  = (int'(in_data.channel) < CHANNELS);
  assign rd_ctrl = stat.rdata[15:0];
  assign ctrl_ok = ((rd_ctrl & PAT_MASK) == PAT_WANT) &&
                   (rd_ctrl[13:12] != MODE_BAD) && (rd_ctrl[15:14] != MODE_BAD);
  assign last = (cur_rem_r == 16'd1);

  // Lowest eligible channel wins.
  always_comb begin
    found    = 1'b0;
    pick_sel = 2'd0;
    for (int i = MAX_CH - 1; i >= 0; i--) begin
      if (stat.elig[i]) begin
        found    = 1'b1;
        pick_sel = 2'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    pick_nxt      = pick_r;
    ctrl_nxt      = ctrl_r;
    run_nxt       = run_r;
    active_nxt    = active_r;
    cur_src_nxt   = cur_src_r;
    cur_dst_nxt   = cur_dst_r;
    cur_rem_nxt   = cur_rem_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd           = '0;

    unique case (state_r)
      ST_IDLE: begin
        cmd.raddr = {in_data.channel, in_data.reg_select};
        if (accept) begin
          req_nxt = in_data;
          if (in_data.func == FN_WRITE && ch_ok) begin
            cmd.we    = 1'b1;
            cmd.waddr = {in_data.channel, in_data.reg_select};
            cmd.wdata = (in_data.reg_select == SEL_CNT || in_data.reg_select == SEL_CTRL)
                        ? {16'd0, in_data.write_data[15:0]} : in_data.write_data;
            // Restart from the programmed values on the next tick.
            if (run_r && active_r == in_data.channel) begin
              run_nxt = 1'b0;
            end
          end else if (in_data.func == FN_READ) begin
            state_nxt = ST_READ;
          end else if (in_data.func == FN_TICK && master_en && found) begin
            cmd.raddr = {pick_sel, SEL_CTRL};
            pick_nxt  = pick_sel;
            state_nxt = ST_CTRL;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt     = 1'b1;
        out_nxt           = '0;
        out_nxt.kind      = KIND_READ;
        out_nxt.read_data = (int'(req_r.channel) < CHANNELS) ? stat.rdata : 32'd0;
        state_nxt         = ST_IDLE;
      end
      ST_CTRL: begin
        ctrl_nxt = rd_ctrl;
        if (!ctrl_ok) begin
          cmd.we    = 1'b1;
          cmd.waddr = {pick_r, SEL_CTRL};
          cmd.wdata = {16'd0, rd_ctrl | CTRL_DONE};
          if (run_r && active_r == pick_r) begin
            run_nxt = 1'b0;
          end
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.kind         = KIND_ERR;
          out_nxt.xfer_channel = pick_r;
          state_nxt            = ST_IDLE;
        end else if (run_r && active_r == pick_r) begin
          state_nxt = ST_XFER;
        end else begin
          cmd.raddr = {pick_r, SEL_SRC};
          state_nxt = ST_SRC;
        end
      end
      ST_SRC: begin
        cur_src_nxt = stat.rdata;
        cmd.raddr   = {pick_r, SEL_DST};
        state_nxt   = ST_DST;
      end
      ST_DST: begin
        cur_dst_nxt = stat.rdata;
        cmd.raddr   = {pick_r, SEL_CNT};
        state_nxt   = ST_CNT;
      end
      ST_CNT: begin
        cur_rem_nxt = stat.rdata[15:0];
        run_nxt     = 1'b1;
        active_nxt  = pick_r;
        state_nxt   = ST_XFER;
      end
      ST_XFER: begin
        out_valid_nxt        = 1'b1;
        out_nxt              = '0;
        out_nxt.kind         = KIND_XFER;
        out_nxt.xfer_channel = pick_r;
        out_nxt.src_addr     = cur_src_r;
        out_nxt.dst_addr     = cur_dst_r;
        out_nxt.word_size    = ctrl_r[3];
        out_nxt.last         = last;
        cur_src_nxt = cur_src_r + mode_step(ctrl_r[13:12], ctrl_r[3]);
        cur_dst_nxt = cur_dst_r + mode_step(ctrl_r[15:14], ctrl_r[3]);
        if (last) begin
          cur_rem_nxt = 16'd0;
          run_nxt     = 1'b0;
          cmd.we      = 1'b1;
          cmd.waddr   = {pick_r, SEL_CTRL};
          cmd.wdata   = {16'd0, ctrl_r | CTRL_DONE};
        end else begin
          cur_rem_nxt = cur_rem_r - 16'd1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= 1'b0;
      active_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    pick_r    <= pick_nxt;
    ctrl_r    <= ctrl_nxt;
    cur_src_r <= cur_src_nxt;
    cur_dst_r <= cur_dst_nxt;
    cur_rem_r <= cur_rem_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/dma_channel_controller_top.sv
// A write gives no result and a read strobes its result from ST_READ. A tick strobes an error
// from ST_CTRL on a bad control word, else a transfer from ST_XFER; a channel not running
// first reloads via ST_SRC, ST_DST, ST_CNT (one register file read per cycle).
// The next request is taken the cycle after a result is registered; results cannot stall.
// Synchronous active-low reset clears control state and all register file valid bits,
// so every channel register reads as zero until written.
module dma_channel_controller_top
  import dcc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_res_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic     master_en_r;
  rf_cmd_t  rf_cmd;
  rf_stat_t rf_stat;

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      master_en_r <= cfg_data;
    end
  end

  dcc_regfile #(
    .CHANNELS (CHANNELS)
  ) u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rf_cmd),
    .stat  (rf_stat)
  );

  dcc_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .master_en (master_en_r),
    .cmd       (rf_cmd),
    .stat      (rf_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: design/dcc_checker.sv
// Port-level checks for the DMA channel controller, bound to the top level.
`include "assert_macros.svh"

module dcc_checker
  import dcc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_data,
  input logic     out_valid,
  input out_res_t out_data
);

  `ASSERT_NEVER(a_kind_known, clk, rst_n, out_valid && out_data.kind != KIND_READ && out_data.kind != KIND_XFER && out_data.kind != KIND_ERR, "result with unknown kind")

  `ASSERT_CLK(a_read_result, clk, rst_n, (start && !busy && in_data.func == FN_READ) |=> ##1 (out_valid && out_data.kind == KIND_READ), "read request without read result")

  `ASSERT_CLK(a_write_silent, clk, rst_n, (start && !busy && in_data.func == FN_WRITE) |=> !out_valid, "write request produced a result")

  `ASSERT_CLK(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "results on adjacent cycles")

  `ASSERT_CLK(a_err_clean, clk, rst_n, (out_valid && out_data.kind == KIND_ERR) |-> (out_data.src_addr == 32'd0 && out_data.dst_addr == 32'd0 && !out_data.last), "error result carries transfer fields")

endmodule

bind dma_channel_controller_top dcc_checker u_dcc_checker (.*);
